// File: src/lru_slot_list_assert.svh
// ----------------------------------------------------------------------------
// lru_slot_list_assert.svh - assertion macros
// Short forms for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef LRU_SLOT_LIST_ASSERT_SVH
`define LRU_SLOT_LIST_ASSERT_SVH

// same-cycle implication
`define LSL_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lru_slot_list assertion failed");

// next-cycle implication
`define LSL_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lru_slot_list assertion failed");

`endif

// File: src/lsl_pkg.sv
// ----------------------------------------------------------------------------
// lsl_pkg - shared definitions for lru_slot_list
// Field widths, default parameters, opcodes and controller/datapath structs.
// ----------------------------------------------------------------------------
package lsl_pkg;

  localparam int SLOT_W       = 10;
  localparam int SLOTS_DEF    = 1024;
  localparam int RESERVED_DEF = 3;

  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic init_wr;
    logic accept;
    logic unlink_wr;
    logic link_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic skip;
  } sts_t;

endpackage

// File: src/lsl_ram.sv
// ----------------------------------------------------------------------------
// lsl_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lsl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/lsl_dpath.sv
// ----------------------------------------------------------------------------
// lsl_dpath - link memories, list ends and result registers
// Holds the next/prev link RAMs, the LRU head and MRU tail, the init sweep
// counter and the output payload register.
// ----------------------------------------------------------------------------
module lsl_dpath #(
  parameter int SLOTS    = lsl_pkg::SLOTS_DEF,
  parameter int RESERVED = lsl_pkg::RESERVED_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lsl_pkg::cmd_t             cmd,
  output lsl_pkg::sts_t             sts,
  input  logic                      in_opcode,
  input  logic [lsl_pkg::SLOT_W-1:0] in_slot_index,
  output logic [lsl_pkg::SLOT_W-1:0] out_slot,
  output logic                      out_bad_slot
);

  localparam int LW    = $clog2(SLOTS);
  localparam bit EMPTY = (RESERVED >= SLOTS);

  function automatic logic [LW-1:0] clamp_slot(input logic [LW-1:0] x);
    return (32'(x) < SLOTS) ? x : '0;
  endfunction

  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] s_r;
  logic [lsl_pkg::SLOT_W-1:0] res_slot_r;
  logic                       res_bad_r;
  logic [lsl_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_bad_r;

  logic [LW-1:0] s_comb;
  logic          bad_comb;
  logic [lsl_pkg::SLOT_W-1:0] res_slot_comb;
  logic          touch_bad;

  logic [LW-1:0] next_rd, prev_rd, nx, pv;
  logic          next_we, prev_we;
  logic [LW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign touch_bad = (32'(in_slot_index) < RESERVED) || (32'(in_slot_index) >= SLOTS);

  always_comb begin
    if (in_opcode == lsl_pkg::OP_ALLOC) begin
      s_comb        = head_r;
      bad_comb      = EMPTY;
      res_slot_comb = EMPTY ? '0 : lsl_pkg::SLOT_W'(head_r);
    end else begin
      s_comb        = LW'(in_slot_index);
      bad_comb      = touch_bad;
      res_slot_comb = in_slot_index;
    end
  end

  assign sts.skip      = bad_comb || (s_comb == tail_r);
  assign sts.init_last = (32'(cnt_r) == SLOTS - 1);

  assign nx = clamp_slot(next_rd);
  assign pv = clamp_slot(prev_rd);

  always_comb begin
    next_we    = 1'b0;
    next_waddr = cnt_r;
    next_wdata = LW'(32'(cnt_r) + 1);
    prev_we    = 1'b0;
    prev_waddr = cnt_r;
    prev_wdata = LW'(32'(cnt_r) - 1);
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    if (cmd.init_wr) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      cnt_nxt = LW'(32'(cnt_r) + 1);
    end else if (cmd.unlink_wr) begin
      if (s_r == head_r) begin
        head_nxt = nx;
      end else begin
        next_we    = 1'b1;
        next_waddr = pv;
        next_wdata = nx;
        prev_we    = 1'b1;
        prev_waddr = nx;
        prev_wdata = pv;
      end
    end else if (cmd.link_wr) begin
      next_we    = 1'b1;
      next_waddr = tail_r;
      next_wdata = s_r;
      prev_we    = 1'b1;
      prev_waddr = s_r;
      prev_wdata = tail_r;
      tail_nxt   = s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= LW'(RESERVED);
      tail_r <= LW'(SLOTS - 1);
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r        <= s_comb;
      res_slot_r <= res_slot_comb;
      res_bad_r  <= bad_comb;
    end
    if (cmd.load_out) begin
      out_slot_r <= res_slot_r;
      out_bad_r  <= res_bad_r;
    end
  end

  lsl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (cmd.accept),
    .raddr (s_comb),
    .rdata (next_rd)
  );

  lsl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (cmd.accept),
    .raddr (s_comb),
    .rdata (prev_rd)
  );

  assign out_slot     = out_slot_r;
  assign out_bad_slot = out_bad_r;

endmodule

// File: src/lsl_ctrl.sv
// ----------------------------------------------------------------------------
// lsl_ctrl - sequencer for lru_slot_list
// Init sweep, then per request: read links, unlink+relink if moving, deliver.
// ----------------------------------------------------------------------------
`include "lru_slot_list_assert.svh"

module lsl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  lsl_pkg::sts_t sts,
  output lsl_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_UNLINK = 5'b00100,
    S_LINK   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.init_wr   = (state_r == S_INIT);
    cmd.accept    = accept;
    cmd.unlink_wr = (state_r == S_UNLINK);
    cmd.link_wr   = (state_r == S_LINK);
    cmd.load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = sts.skip ? S_DONE : S_UNLINK;
      end
      S_UNLINK: state_nxt = S_LINK;
      S_LINK:   state_nxt = S_DONE;
      S_DONE: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `LSL_ASSERT_NXT(a_move_path, clk, rst_n, accept && !sts.skip, state_r == S_UNLINK)
  `LSL_ASSERT_NXT(a_unlink_link, clk, rst_n, state_r == S_UNLINK, state_r == S_LINK)
  `LSL_ASSERT_IMP(a_init_quiet, clk, rst_n, state_r == S_INIT, !out_valid_r)
  `LSL_ASSERT_NXT(a_done_hold, clk, rst_n,
                  state_r == S_DONE && out_valid_r && !out_ready, state_r == S_DONE)

endmodule

// File: src/lru_slot_list.sv
// ----------------------------------------------------------------------------
// lru_slot_list - LRU recency list over cache slots
// Doubly linked list of slots RESERVED..SLOTS-1; touch moves a slot to the
// MRU end, allocate takes the LRU slot and moves it to the MRU end.
// ----------------------------------------------------------------------------
// After reset the block sweeps all SLOTS entries (1024 by default) of the
// link RAMs with in_ready low. A request that moves a slot goes through
// accept with link read, unlink write, relink write and result load; a bad
// touch, a touch of the MRU slot or an allocate that moves nothing goes
// from accept straight to result load. The single write port of each link
// RAM forces unlink and relink into separate cycles. One request is in
// work at a time; a new one is accepted while the last result waits in the
// output register.
module lru_slot_list #(
  parameter int SLOTS    = lsl_pkg::SLOTS_DEF,
  parameter int RESERVED = lsl_pkg::RESERVED_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [lsl_pkg::SLOT_W-1:0] in_slot_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lsl_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_bad_slot
);

  lsl_pkg::cmd_t cmd;
  lsl_pkg::sts_t sts;

  lsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsl_dpath #(.SLOTS(SLOTS), .RESERVED(RESERVED)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_opcode),
    .in_slot_index (in_slot_index),
    .out_slot      (out_slot),
    .out_bad_slot  (out_bad_slot)
  );

endmodule

// File: test/lru_slot_list_test.sv
// ----------------------------------------------------------------------------
// lru_slot_list_test - self-checking regression for lru_slot_list
// Drives touch and allocate requests through the valid/ready input, mirrors
// the recency list in a local linked-list model and checks every result
// (slot, bad_slot) in order. Both sides idle at random, with one quiet window.
// ----------------------------------------------------------------------------
module lru_slot_list_test;

  localparam int NSLOTS      = lsl_pkg::SLOTS_DEF;
  localparam int NRESERVED   = lsl_pkg::RESERVED_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_REQS   = 850;

  typedef struct packed {
    logic                       op;
    logic [lsl_pkg::SLOT_W-1:0] idx;
    logic                       drain;
  } slot_req_t;

  typedef struct packed {
    logic [lsl_pkg::SLOT_W-1:0] slot;
    logic                       bad;
  } slot_result_t;

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic                       in_opcode     = lsl_pkg::OP_TOUCH;
  logic [lsl_pkg::SLOT_W-1:0] in_slot_index = '0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic [lsl_pkg::SLOT_W-1:0] out_slot;
  logic                       out_bad_slot;

  slot_req_t    pending_reqs[$];
  slot_result_t expected_results[$];
  slot_req_t    next_req;
  slot_result_t want;

  logic [lsl_pkg::SLOT_W-1:0] next_link[NSLOTS];
  logic [lsl_pkg::SLOT_W-1:0] prev_link[NSLOTS];
  logic [lsl_pkg::SLOT_W-1:0] lru_head;
  logic [lsl_pkg::SLOT_W-1:0] mru_tail;

  logic req_taken   = 1'b0;
  int   req_count   = 0;
  int   result_count = 0;
  int   mismatches  = 0;
  int   cycle_count = 0;
  wire  quiet       = (req_count >= 250) && (req_count < 420);

  lru_slot_list u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_slot_index(in_slot_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_slot     (out_slot),
    .out_bad_slot (out_bad_slot)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch on result %0d: %s expected %0d got %0d",
             result_count, what, exp_v, got_v);
    mismatches++;
  endtask

  function automatic void move_to_mru(input logic [lsl_pkg::SLOT_W-1:0] s);
    logic [lsl_pkg::SLOT_W-1:0] nx;
    logic [lsl_pkg::SLOT_W-1:0] pv;
    if (s == mru_tail)
      return;
    nx = next_link[s];
    if (s == lru_head) begin
      lru_head = nx;
    end else begin
      pv = prev_link[s];
      next_link[pv] = nx;
      prev_link[nx] = pv;
    end
    next_link[mru_tail] = s;
    prev_link[s] = mru_tail;
    mru_tail = s;
  endfunction

  function automatic slot_result_t predict_recency(input logic op,
                                                   input logic [lsl_pkg::SLOT_W-1:0] idx);
    slot_result_t r;
    if (op == lsl_pkg::OP_ALLOC) begin
      if (NRESERVED >= NSLOTS) begin
        r.slot = '0;
        r.bad  = 1'b1;
      end else begin
        r.slot = lru_head;
        r.bad  = 1'b0;
        move_to_mru(lru_head);
      end
    end else begin
      r.slot = idx;
      if (int'(idx) < NRESERVED || int'(idx) >= NSLOTS) begin
        r.bad = 1'b1;
      end else begin
        r.bad = 1'b0;
        move_to_mru(idx);
      end
    end
    return r;
  endfunction

  task automatic add_req(input logic op, input int idx, input logic drain);
    slot_req_t q;
    q.op    = op;
    q.idx   = idx[lsl_pkg::SLOT_W-1:0];
    q.drain = drain;
    pending_reqs.push_back(q);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 12);
      if (!in_valid || req_taken) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].drain && expected_results.size() != 0) &&
            (quiet || $urandom_range(99) >= 12)) begin
          next_req = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          in_opcode     <= next_req.op;
          in_slot_index <= next_req.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", 0, int'(out_slot));
        end else begin
          want = expected_results.pop_front();
          if (out_slot !== want.slot)
            report_mismatch("slot", int'(want.slot), int'(out_slot));
          if (out_bad_slot !== want.bad)
            report_mismatch("bad_slot", int'(want.bad), int'(out_bad_slot));
        end
        result_count++;
      end
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_recency(in_opcode, in_slot_index));
        req_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lru_slot_list regression: fail");
      $finish;
    end
  end

  initial begin
    int r;
    int last_touch;
    for (int k = 0; k < NSLOTS; k++) begin
      next_link[k] = lsl_pkg::SLOT_W'(k + 1);
      prev_link[k] = lsl_pkg::SLOT_W'(k - 1);
    end
    lru_head = lsl_pkg::SLOT_W'(NRESERVED);
    mru_tail = lsl_pkg::SLOT_W'(NSLOTS - 1);

    // directed: reserved slots, list ends, repeated MRU touch, allocs
    add_req(lsl_pkg::OP_TOUCH, 0, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 1, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NRESERVED - 1, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NSLOTS - 1, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NRESERVED, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NRESERVED, 1'b0);
    add_req(lsl_pkg::OP_ALLOC, 0, 1'b0);
    add_req(lsl_pkg::OP_ALLOC, 1023, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 500, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 'h2AA, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 'h155, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NSLOTS - 2, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NSLOTS - 1, 1'b0);
    add_req(lsl_pkg::OP_ALLOC, 'h155, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, NRESERVED + 3, 1'b0);
    add_req(lsl_pkg::OP_ALLOC, 'h2AA, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 500, 1'b0);
    add_req(lsl_pkg::OP_ALLOC, 0, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 1023, 1'b0);
    add_req(lsl_pkg::OP_TOUCH, 0, 1'b0);

    last_touch = NRESERVED;
    for (int n = 0; n < RAND_REQS; n++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        add_req(lsl_pkg::OP_ALLOC, $urandom_range(1023), n == 0 || n == 600);
      end else if (r < 48) begin
        add_req(lsl_pkg::OP_TOUCH, $urandom_range(NRESERVED - 1), n == 0 || n == 600);
      end else begin
        if (r < 58)
          ;
        else if (r < 78)
          last_touch = $urandom_range(NRESERVED + 31, NRESERVED);
        else if (r < 85)
          last_touch = $urandom_range(NSLOTS - 1, NSLOTS - 24);
        else
          last_touch = $urandom_range(1023);
        add_req(lsl_pkg::OP_TOUCH, last_touch, n == 0 || n == 600);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("lru_slot_list regression: pass");
    else
      $display("lru_slot_list regression: fail");
    $finish;
  end

endmodule
